>>> rtl/interval_union_coverage_core_assert.svh
// Assertion macros for the interval union coverage block.
// Included by RTL files that carry concurrent checks.
`ifndef INTERVAL_UNION_COVERAGE_CORE_ASSERT_SVH
`define INTERVAL_UNION_COVERAGE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define IUC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define IUC_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define IUC_ASSERT(label, clk, rst_n, prop)
`define IUC_ASSERT_RST(label, clk, prop)
`endif
`endif

>>> rtl/iuc_pkg.sv
// Shared constants for the interval union coverage block.
// No dependencies.
`default_nettype none
package iuc_pkg;
    localparam int MAX_INTERVALS = 64;
    localparam int IDX_W = $clog2(MAX_INTERVALS);
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int SUM_W = 32 + IDX_W + 1;
    localparam int NUM_W = SUM_W + 14;
    localparam logic [13:0] FULL_SCALE = 14'd10000;
endpackage
`default_nettype wire

>>> rtl/interval_union_coverage_core.sv
// Top level of the interval union coverage block.
// Uses iuc_pkg and interval_union_coverage_core_assert.svh.
// Flow: for a matched call each stored entry is read and checked (S_RD, S_CHK), then
// the merged interval is inserted (S_INS); an unmatched beat that is not last leaves
// the block idle. A last beat adds a sum pass over the entries (S_SRD, S_SUMW, S_SACC),
// a setup state (S_DIV0), a 53-step restoring divide (skipped when not available) and
// a state to latch the result (S_FIN). Throughput: one beat in flight.
// Reset: async active low clears control and group counters; store needs none.
`default_nettype none
`include "interval_union_coverage_core_assert.svh"
module interval_union_coverage_core
    import iuc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] target_start,
    input  wire logic [31:0] target_stop,
    input  wire logic [7:0]  target_chrom,
    input  wire logic [15:0] target_subject,
    input  wire logic [3:0]  target_copies,
    input  wire logic        call_present,
    input  wire logic [31:0] call_start,
    input  wire logic [31:0] call_stop,
    input  wire logic [7:0]  call_chrom,
    input  wire logic [15:0] call_subject,
    input  wire logic [3:0]  call_copies,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [13:0]      coverage_hundredths,
    output logic [15:0]      accepted_count,
    output logic             not_available,
    output logic             store_overflow
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_SRD   = 4'd4;
    localparam logic [3:0] S_SACC  = 4'd5;
    localparam logic [3:0] S_DIV0  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_SUMW  = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    logic [31:0] mem_lo [MAX_INTERVALS];
    logic [31:0] mem_hi [MAX_INTERVALS];
    logic [31:0] rd_lo_reg, rd_hi_reg;
    logic        we;
    logic [IDX_W-1:0] wa, ra;
    logic [31:0] wd_lo, wd_hi;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_lo[wa] <= wd_lo;
            mem_hi[wa] <= wd_hi;
        end
        rd_lo_reg <= mem_lo[ra];
        rd_hi_reg <= mem_hi[ra];
    end

    logic [3:0]       state_reg;
    logic [CNT_W-1:0] count_reg, rd_idx_reg, keep_reg;
    logic [15:0]      tally_reg;
    logic             ovf_reg, merged_reg, last_reg;
    logic [31:0]      lo_reg, hi_reg, len_reg;
    logic             tgt_ok_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [13:0]      q_reg;
    logic [5:0]       step_reg;
    logic [13:0]      cov_reg;
    logic [15:0]      cnt_out_reg;
    logic             na_reg, ovf_out_reg;

    logic [31:0] lo_c, hi_c;
    logic        match_c;
    assign lo_c = (target_start > call_start) ? target_start : call_start;
    assign hi_c = (target_stop < call_stop) ? target_stop : call_stop;
    assign match_c = call_present && target_chrom == call_chrom &&
                     target_subject == call_subject && target_copies == call_copies &&
                     hi_c > lo_c;

    logic        touch;
    assign touch = rd_lo_reg <= hi_reg && lo_reg <= rd_hi_reg;

    logic [NUM_W-1:0] rem_sh;
    logic [NUM_W-1:0] len_ext;
    logic             div_ge;
    assign len_ext = {{(NUM_W-32){1'b0}}, len_reg};
    assign rem_sh = {rem_reg[NUM_W-2:0], num_reg[NUM_W-1]};
    assign div_ge = rem_sh >= len_ext;

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign coverage_hundredths = cov_reg;
    assign accepted_count = cnt_out_reg;
    assign not_available = na_reg;
    assign store_overflow = ovf_out_reg;

    always_comb
    begin
        we = 1'b0;
        wa = keep_reg[IDX_W-1:0];
        wd_lo = rd_lo_reg;
        wd_hi = rd_hi_reg;
        ra = rd_idx_reg[IDX_W-1:0];
        if (state_reg == S_CHK && !touch)
            we = 1'b1;
        if (state_reg == S_INS && keep_reg < CNT_W'(MAX_INTERVALS))
        begin
            we = 1'b1;
            wd_lo = lo_reg;
            wd_hi = hi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            tally_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        lo_reg <= lo_c;
                        hi_reg <= hi_c;
                        last_reg <= last;
                        tgt_ok_reg <= target_stop > target_start;
                        len_reg <= target_stop - target_start;
                        rd_idx_reg <= '0;
                        keep_reg <= '0;
                        merged_reg <= 1'b0;
                        sum_reg <= '0;
                        if (match_c)
                        begin
                            if (tally_reg != 16'hFFFF)
                                tally_reg <= tally_reg + 16'd1;
                            state_reg <= (count_reg == '0) ? S_INS : S_RD;
                        end
                        else
                            state_reg <= last ? S_SRD : S_IDLE;
                    end
                end
                S_RD:
                    state_reg <= S_CHK;
                S_CHK:
                begin
                    if (touch)
                    begin
                        if (rd_lo_reg < lo_reg) lo_reg <= rd_lo_reg;
                        if (rd_hi_reg > hi_reg) hi_reg <= rd_hi_reg;
                        merged_reg <= 1'b1;
                    end
                    else
                        keep_reg <= keep_reg + CNT_W'(1);
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    state_reg <= (rd_idx_reg + CNT_W'(1) == count_reg) ? S_INS : S_RD;
                end
                S_INS:
                begin
                    if (keep_reg < CNT_W'(MAX_INTERVALS))
                        count_reg <= keep_reg + CNT_W'(1);
                    else
                    begin
                        count_reg <= keep_reg;
                        if (!merged_reg) ovf_reg <= 1'b1;
                    end
                    rd_idx_reg <= '0;
                    state_reg <= last_reg ? S_SRD : S_IDLE;
                end
                S_SRD:
                    state_reg <= (count_reg == '0) ? S_DIV0 : S_SUMW;
                S_SUMW:
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                    state_reg <= S_SACC;
                end
                S_SACC:
                begin
                    sum_reg <= sum_reg + SUM_W'(rd_hi_reg - rd_lo_reg);
                    state_reg <= (rd_idx_reg == count_reg) ? S_DIV0 : S_SUMW;
                end
                S_DIV0:
                begin
                    num_reg <= NUM_W'(sum_reg) * NUM_W'(FULL_SCALE)
                               + NUM_W'(len_reg[31:1]);
                    rem_reg <= '0;
                    q_reg <= '0;
                    step_reg <= '0;
                    na_reg <= !tgt_ok_reg || sum_reg == '0;
                    state_reg <= (!tgt_ok_reg || sum_reg == '0) ? S_OUT : S_DIV;
                    cov_reg <= '0;
                    cnt_out_reg <= tally_reg;
                    ovf_out_reg <= ovf_reg;
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    rem_reg <= div_ge ? rem_sh - len_ext : rem_sh;
                    q_reg <= (q_reg >= 14'd5000) ? FULL_SCALE : {q_reg[12:0], div_ge};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(NUM_W - 1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    cov_reg <= q_reg;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        count_reg <= '0;
                        tally_reg <= '0;
                        ovf_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `IUC_ASSERT(a_count_range, clk, rst_n, count_reg <= CNT_W'(MAX_INTERVALS))
    `IUC_ASSERT(a_out_bound, clk, rst_n, out_valid |-> cov_reg <= FULL_SCALE)
    `IUC_ASSERT(a_na_zero, clk, rst_n, (out_valid && na_reg) |-> cov_reg == '0)
    `IUC_ASSERT(a_ready_excl, clk, rst_n, !(in_ready && out_valid))
endmodule
`default_nettype wire
